// ----- hdl/match_displacement_outlier_filter_macros.svh -----
// Assertion macros for the match displacement outlier filter.
// Used by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef MATCH_DISPLACEMENT_OUTLIER_FILTER_MACROS_SVH
`define MATCH_DISPLACEMENT_OUTLIER_FILTER_MACROS_SVH

// clocked property, off during reset
`define MDOF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define MDOF_ASSERT_NEVER(label, expr, msg) \
    `MDOF_ASSERT(label, !(expr), msg)

`endif

// ----- hdl/mdof_pkg.sv -----
// Shared constants, codes and types for the match displacement outlier filter.
// No dependencies.
`timescale 1ns / 1ps

package mdof_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int COORD_W      = 20;
    localparam int SHIFT_W      = 21;
    localparam int DIFF_W       = 23;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int RAD_W        = 48;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int DIST_W       = 22;
    localparam int SUM_W        = 28;
    localparam int WIN_W        = 7;
    localparam int CMP_W        = 31;
    localparam int SQRT_BITS    = 6;
    localparam int SQRT_CYCLES  = ROOT_W / SQRT_BITS;
    localparam int SQRT_CNT_W   = $clog2(SQRT_CYCLES);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 21;

    localparam logic [1:0] SHIFT_NONE    = 2'd0;
    localparam logic [1:0] SHIFT_X_MINUS = 2'd1;
    localparam logic [1:0] SHIFT_X_PLUS  = 2'd2;
    localparam logic [1:0] SHIFT_Y_PLUS  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = 7'd10;

    typedef struct packed {
        logic [1:0]                shift_mode;
        logic signed [SHIFT_W-1:0] shift_amount;
        logic [WIN_W-1:0]          window_size;
    } cfg_t;

    typedef struct packed {
        logic [RAD_W-1:0] radicand;
        logic             last;
    } sq_item_t;

endpackage

// ----- hdl/mdof_front.sv -----
// Front end: accepts point pairs, applies the target shift, forms squared distance.
// Depends on mdof_pkg; feeds mdof_fifo.
`timescale 1ns / 1ps

module mdof_front
    import mdof_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] src_x,
    input  logic [COORD_W-1:0] src_y,
    input  logic [COORD_W-1:0] tgt_x,
    input  logic [COORD_W-1:0] tgt_y,
    input  logic               last_point,
    input  logic               fifo_full,
    output logic               push,
    output sq_item_t           push_item
);

    logic                     adv;
    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     s1_last_reg;
    logic                     s2_last_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] shift_ext;
    logic signed [DIFF_W-1:0] tx_adj;
    logic signed [DIFF_W-1:0] ty_adj;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic [RAD_W-1:0]         sqx_reg;
    logic [RAD_W-1:0]         sqy_reg;

    assign adv      = !(s2_valid_reg && fifo_full);
    assign in_stall = !adv;

    assign shift_ext = {{(DIFF_W-SHIFT_W){cfg.shift_amount[SHIFT_W-1]}}, cfg.shift_amount};

    always_comb
    begin
        tx_adj = $signed({{(DIFF_W-COORD_W){1'b0}}, tgt_x});
        ty_adj = $signed({{(DIFF_W-COORD_W){1'b0}}, tgt_y});
        case (cfg.shift_mode)
            SHIFT_X_MINUS: tx_adj = tx_adj - shift_ext;
            SHIFT_X_PLUS:  tx_adj = tx_adj + shift_ext;
            SHIFT_Y_PLUS:  ty_adj = ty_adj + shift_ext;
            default:       ;
        endcase
        dx_next = $signed({{(DIFF_W-COORD_W){1'b0}}, src_x}) - tx_adj;
        dy_next = $signed({{(DIFF_W-COORD_W){1'b0}}, src_y}) - ty_adj;
    end

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            s1_last_reg <= last_point;
            sqx_reg     <= {{(RAD_W-PROD_W){1'b0}}, prod_x};
            sqy_reg     <= {{(RAD_W-PROD_W){1'b0}}, prod_y};
            s2_last_reg <= s1_last_reg;
        end
    end

    assign push               = s2_valid_reg && !fifo_full;
    assign push_item.radicand = sqx_reg + sqy_reg;
    assign push_item.last     = s2_last_reg;

endmodule

// ----- hdl/mdof_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on mdof_pkg.
`timescale 1ns / 1ps

module mdof_fifo
    import mdof_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sq_item_t push_item,
    output logic     full,
    input  logic     pop,
    output sq_item_t pop_item,
    output logic     empty
);

    sq_item_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- hdl/mdof_sqrt.sv -----
// Iterative integer square root, several result bits per cycle.
// Depends on mdof_pkg; used by mdof_back.
`timescale 1ns / 1ps

module mdof_sqrt
    import mdof_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [DIST_W-1:0] root
);

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [RAD_W-1:0]      rad_next;
    logic [REM_W-1:0]      rem_next;
    logic [ROOT_W-1:0]     root_next;

    always_comb
    begin
        logic [REM_W-1:0] trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        for (int k = 0; k < SQRT_BITS; k++)
        begin
            rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
            rad_next = {rad_next[RAD_W-3:0], 2'b00};
            trial    = {1'b0, root_next, 2'b01};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_next[ROOT_W-2:0], 1'b1};
            end
            else
                root_next = {root_next[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SQRT_CNT_W'(SQRT_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg[DIST_W-1:0];

endmodule

// ----- hdl/mdof_back.sv -----
// Back end: square root, distance store, mean tests, in-span marking and emission.
// Depends on mdof_pkg, mdof_sqrt and the assertion macro header.
`timescale 1ns / 1ps
`include "match_displacement_outlier_filter_macros.svh"

module mdof_back
    import mdof_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WIN_W-1:0]  window_size,
    input  logic              fifo_empty,
    input  sq_item_t          pop_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  point_index,
    output logic              passes,
    output logic              in_span,
    output logic [DIST_W-1:0] distance,
    output logic              overflow,
    output logic              last_result
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ROOT      = 3'd1;
    localparam logic [2:0] ST_WIN       = 3'd2;
    localparam logic [2:0] ST_MUL       = 3'd3;
    localparam logic [2:0] ST_CMP       = 3'd4;
    localparam logic [2:0] ST_EMIT_RD   = 3'd5;
    localparam logic [2:0] ST_EMIT_LD   = 3'd6;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd7;

    logic [2:0]            state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SUM_W-1:0]      total_reg;
    logic                  ovf_reg;
    logic                  set_last_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [MAX_POINTS-1:0] flags_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [IDX_W-1:0]      lastp_reg;

    logic [DIST_W-1:0]     dist_mem [MAX_POINTS];
    logic [SUM_W-1:0]      psum_mem [MAX_POINTS];
    logic [DIST_W-1:0]     d_rd_reg;
    logic [SUM_W-1:0]      s_hi_rd_reg;
    logic [SUM_W-1:0]      s_lo_rd_reg;
    logic                  lo_zero_reg;
    logic [WIN_W-1:0]      win_cnt_reg;

    logic [SUM_W+CNT_W-1:0] prod_g_reg;
    logic [SUM_W+CNT_W-1:0] prod_l_reg;
    logic [SUM_W-1:0]       wsum_reg;

    logic                  out_valid_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_pass_reg;
    logic                  out_span_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic                  out_ovf_reg;
    logic                  out_last_reg;

    logic                  sq_start;
    logic                  sq_done;
    logic [DIST_W-1:0]     sq_root;
    logic                  mem_we;
    logic [IDX_W-1:0]      radius;
    logic [WIN_W-1:0]      lo;
    logic [WIN_W-1:0]      hi;
    logic [WIN_W:0]        hi_far;
    logic [IDX_W-1:0]      hi_addr;
    logic [IDX_W-1:0]      lo_addr;
    logic                  at_end;
    logic                  g_ok;
    logic                  l_ok;
    logic [CMP_W-1:0]      lhs_g;
    logic [CMP_W-1:0]      lhs_l;
    logic [CMP_W-1:0]      rhs_g;
    logic [CMP_W-1:0]      rhs_l;
    logic                  room;
    logic                  out_take;

    mdof_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (pop_item.radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign room     = (count_reg < CNT_W'(MAX_POINTS));
    assign pop      = (state_reg == ST_IDLE) && !fifo_empty;
    assign sq_start = pop && room;
    assign mem_we   = (state_reg == ST_ROOT) && sq_done;
    assign at_end   = ({1'b0, idx_reg} + 1'b1) == count_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        radius = window_size[WIN_W-1:1];
        hi_far = {2'b00, idx_reg} + {2'b00, radius} + 1'b1;
        if (idx_reg < radius)
        begin
            lo = '0;
            hi = (window_size < count_reg) ? window_size : count_reg;
        end
        else
        begin
            lo = {1'b0, idx_reg - radius};
            hi = (hi_far < {1'b0, count_reg}) ? hi_far[WIN_W-1:0] : count_reg;
        end
        hi_addr = IDX_W'(hi - 1'b1);
        lo_addr = IDX_W'(lo - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dist_mem[count_reg[IDX_W-1:0]] <= sq_root;
            psum_mem[count_reg[IDX_W-1:0]] <= total_reg + SUM_W'(sq_root);
        end
        d_rd_reg    <= dist_mem[idx_reg];
        s_hi_rd_reg <= psum_mem[hi_addr];
        s_lo_rd_reg <= psum_mem[lo_addr];
        lo_zero_reg <= (lo == '0);
        win_cnt_reg <= hi - lo;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_g_reg <= d_rd_reg * count_reg;
            prod_l_reg <= d_rd_reg * win_cnt_reg;
            wsum_reg   <= lo_zero_reg ? s_hi_rd_reg : (s_hi_rd_reg - s_lo_rd_reg);
        end
    end

    assign lhs_g = {prod_g_reg[CMP_W-2:0], 1'b0};
    assign lhs_l = {prod_l_reg[CMP_W-2:0], 1'b0};
    assign rhs_g = CMP_W'({total_reg, 1'b0}) + CMP_W'(total_reg);
    assign rhs_l = CMP_W'({wsum_reg, 1'b0}) + CMP_W'(wsum_reg);
    assign g_ok  = (lhs_g <= rhs_g);
    assign l_ok  = (lhs_l <= rhs_l);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            set_last_reg  <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        set_last_reg <= pop_item.last;
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        if (room)
                            state_reg <= ST_ROOT;
                        else
                        begin
                            ovf_reg <= 1'b1;
                            if (pop_item.last)
                                state_reg <= ST_WIN;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (sq_done)
                    begin
                        total_reg <= total_reg + SUM_W'(sq_root);
                        count_reg <= count_reg + 1'b1;
                        state_reg <= set_last_reg ? ST_WIN : ST_IDLE;
                    end
                end
                ST_WIN:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_CMP;
                ST_CMP:
                begin
                    if (g_ok && l_ok && !found_reg)
                        found_reg <= 1'b1;
                    if (at_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_WIN;
                    end
                end
                ST_EMIT_RD:
                    state_reg <= ST_EMIT_LD;
                ST_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (at_end)
                        begin
                            count_reg <= '0;
                            total_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            flags_reg[idx_reg] <= g_ok && l_ok;
            if (g_ok && l_ok)
            begin
                if (!found_reg)
                    first_reg <= idx_reg;
                lastp_reg <= idx_reg;
            end
        end
        if (state_reg == ST_EMIT_LD)
        begin
            out_idx_reg  <= idx_reg;
            out_pass_reg <= flags_reg[idx_reg];
            out_span_reg <= found_reg && (idx_reg >= first_reg) && (idx_reg <= lastp_reg);
            out_dist_reg <= d_rd_reg;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= at_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_index = out_idx_reg;
    assign passes      = out_pass_reg;
    assign in_span     = out_span_reg;
    assign distance    = out_dist_reg;
    assign overflow    = out_ovf_reg;
    assign last_result = out_last_reg;

    `MDOF_ASSERT(a_start_room, sq_start |-> room, "root started with store full")
    `MDOF_ASSERT_NEVER(a_pop_busy, pop && (state_reg != ST_IDLE), "queue popped while busy")
    `MDOF_ASSERT(a_out_state, out_valid_reg |-> (state_reg == ST_EMIT_WAIT), "result outside emit")
    `MDOF_ASSERT(a_set_clear, (out_take && out_last_reg) |=> (count_reg == '0), "set not cleared")

endmodule

// ----- hdl/match_displacement_outlier_filter.sv -----
// Top level of the match displacement outlier filter: configuration registers and wiring.
// Depends on mdof_pkg, mdof_front, mdof_fifo and mdof_back.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one matched point pair per item;
//   last_point closes the set. Output channel (out_valid / out_stall) gives one
//   result item per stored pair, in load order, after the set is closed.
//   Configuration is written on cfg_valid / cfg_ready (always ready), index
//   cfg_index: 0 shift_mode, 1 shift_amount, 2 window_size; other indices ignored.
//   Write configuration only while the block is idle.
// Timing:
//   The front end forms the squared distance in two register stages and queues
//   it; for each pair the back end takes the item from the queue, forms the
//   square root at 6 bits per cycle and writes the store before the next item.
//   After the last pair it runs the window and mean tests for each stored pair
//   (window, multiply, compare states), then emits results one at a time.
//   Up to 64 pairs are kept; further pairs are dropped and flagged.
// Reset clears the set, the queue and the registers (window_size to 10).
// A stalled result holds; input continues to be queued until the queue fills.
`timescale 1ns / 1ps

module match_displacement_outlier_filter
    import mdof_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_W-1:0]    src_x,
    input  logic [COORD_W-1:0]    src_y,
    input  logic [COORD_W-1:0]    tgt_x,
    input  logic [COORD_W-1:0]    tgt_y,
    input  logic                  last_point,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      point_index,
    output logic                  passes,
    output logic                  in_span,
    output logic [DIST_W-1:0]     distance,
    output logic                  overflow,
    output logic                  last_result
);

    cfg_t     cfg_reg;
    logic     push;
    sq_item_t push_item;
    logic     fifo_full;
    logic     fifo_empty;
    logic     pop;
    sq_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_mode   <= SHIFT_NONE;
            cfg_reg.shift_amount <= '0;
            cfg_reg.window_size  <= WINDOW_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SHIFT_MODE:   cfg_reg.shift_mode   <= cfg_data[1:0];
                CFG_SHIFT_AMOUNT: cfg_reg.shift_amount <= $signed(cfg_data[SHIFT_W-1:0]);
                CFG_WINDOW_SIZE:  cfg_reg.window_size  <= cfg_data[WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    mdof_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .src_x      (src_x),
        .src_y      (src_y),
        .tgt_x      (tgt_x),
        .tgt_y      (tgt_y),
        .last_point (last_point),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_item  (push_item)
    );

    mdof_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    mdof_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (cfg_reg.window_size),
        .fifo_empty  (fifo_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_index (point_index),
        .passes      (passes),
        .in_span     (in_span),
        .distance    (distance),
        .overflow    (overflow),
        .last_result (last_result)
    );

endmodule
